/* hw/rtl/assert_macros.svh */
// assertion helpers for the conv layer blocks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define TCONV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define TCONV_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define TCONV_ASSERT(label, clk, rst, prop, msg)

`define TCONV_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

/* hw/rtl/tconv_pkg.sv */
package tconv_pkg;

   localparam int KIND_W      = 2;
   localparam int CH_W        = 6;
   localparam int TAP_FIELD_W = 2;
   localparam int VALUE_W     = 16;
   localparam int CH_LIMIT    = 64;
   // weight address room for 64 x 64 channels and up to 8 taps
   localparam int WADDR_MAX_W = 15;

   localparam logic [KIND_W-1:0] KIND_WEIGHT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BIAS    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd3;

   typedef enum logic [2:0] {
      CMD_WEIGHT  = 3'd0,
      CMD_BIAS    = 3'd1,
      CMD_SAMPLE  = 3'd2,
      CMD_COMPUTE = 3'd3,
      CMD_ABSENT  = 3'd4
   } cmd_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [CH_W-1:0]        channel;
      logic [WADDR_MAX_W-1:0] waddr;
      logic [VALUE_W-1:0]     value;
      logic                   frame_end;
   } qentry_type;

endpackage

/* hw/rtl/tconv_ram.sv */
module tconv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/tconv_queue.sv */
`include "assert_macros.svh"

module tconv_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tconv_pkg::qentry_type push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  valid,
   output tconv_pkg::qentry_type head
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;

   tconv_pkg::qentry_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign valid = (count_ff != '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `TCONV_ASSERT(a_pop_not_empty, clock, reset, pop |-> (count_ff != '0), "pop from empty queue")
   `TCONV_ASSERT(a_push_not_full, clock, reset, push |-> !full, "push into full queue")
   `TCONV_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue count overflow")

endmodule

/* hw/rtl/tconv_front.sv */
module tconv_front #(
   parameter int OUT_CHANNELS = 64,
   parameter int IN_CHANNELS  = 64,
   parameter int KERNEL_TAPS  = 3
) (
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [tconv_pkg::KIND_W-1:0]          req_kind,
   input  logic [tconv_pkg::CH_W-1:0]            req_out_channel,
   input  logic [tconv_pkg::CH_W-1:0]            req_in_channel,
   input  logic [tconv_pkg::TAP_FIELD_W-1:0]     req_tap,
   input  logic [tconv_pkg::VALUE_W-1:0]         req_value,
   input  logic                                  full,
   output logic                                  push,
   output tconv_pkg::qentry_type                 push_entry
);

   localparam int CH_LIMIT = tconv_pkg::CH_LIMIT;
   localparam int EFF_OC = (OUT_CHANNELS < CH_LIMIT) ? OUT_CHANNELS : CH_LIMIT;
   localparam int EFF_IC = (IN_CHANNELS < CH_LIMIT) ? IN_CHANNELS : CH_LIMIT;
   localparam int CH_W   = tconv_pkg::CH_W;
   localparam int TAP_CW = 4;
   localparam int WA_W   = tconv_pkg::WADDR_MAX_W;
   localparam int ROW_LEN = EFF_IC * KERNEL_TAPS;
   // a frame only ends if its last channel fits the sample field
   localparam bit FRAME_CAN_END = (IN_CHANNELS <= CH_LIMIT);

   logic oc_ok, ic_ok, tap_ok, keep, accept;
   logic [CH_W-1:0] ic_sel;
   logic [tconv_pkg::TAP_FIELD_W-1:0] tap_sel;

   assign oc_ok  = ({1'b0, req_out_channel} < (CH_W+1)'(EFF_OC));
   assign ic_ok  = ({1'b0, req_in_channel} < (CH_W+1)'(EFF_IC));
   assign tap_ok = (TAP_CW'(req_tap) < TAP_CW'(KERNEL_TAPS));

   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign push      = accept && keep;

   always_comb begin
      keep                 = 1'b0;
      ic_sel               = '0;
      tap_sel              = '0;
      push_entry.cmd       = tconv_pkg::CMD_WEIGHT;
      push_entry.channel   = req_out_channel;
      push_entry.value     = req_value;
      push_entry.frame_end = 1'b0;
      unique case (req_kind)
         tconv_pkg::KIND_WEIGHT: begin
            push_entry.cmd = tconv_pkg::CMD_WEIGHT;
            keep           = oc_ok && ic_ok && tap_ok;
            ic_sel         = req_in_channel;
            tap_sel        = req_tap;
         end
         tconv_pkg::KIND_BIAS: begin
            push_entry.cmd = tconv_pkg::CMD_BIAS;
            keep           = oc_ok;
         end
         tconv_pkg::KIND_SAMPLE: begin
            push_entry.cmd       = tconv_pkg::CMD_SAMPLE;
            push_entry.channel   = req_in_channel;
            keep                 = ic_ok;
            push_entry.frame_end = FRAME_CAN_END &&
                                   (req_in_channel == CH_W'(IN_CHANNELS - 1));
         end
         tconv_pkg::KIND_COMPUTE: begin
            push_entry.cmd = oc_ok ? tconv_pkg::CMD_COMPUTE : tconv_pkg::CMD_ABSENT;
            keep           = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      push_entry.waddr = WA_W'(req_out_channel) * WA_W'(ROW_LEN)
                       + WA_W'(ic_sel) * WA_W'(KERNEL_TAPS)
                       + WA_W'(tap_sel);
   end

endmodule

/* hw/rtl/tconv_back.sv */
`include "assert_macros.svh"

module tconv_back #(
   parameter int OUT_CHANNELS = 64,
   parameter int IN_CHANNELS  = 64,
   parameter int KERNEL_TAPS  = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  tconv_pkg::qentry_type              q_entry,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tconv_pkg::CH_W-1:0]         rsp_result_channel,
   output logic [tconv_pkg::VALUE_W-1:0]      rsp_result_value
);

   localparam int CH_LIMIT = tconv_pkg::CH_LIMIT;
   localparam int EFF_OC  = (OUT_CHANNELS < CH_LIMIT) ? OUT_CHANNELS : CH_LIMIT;
   localparam int EFF_IC  = (IN_CHANNELS < CH_LIMIT) ? IN_CHANNELS : CH_LIMIT;
   localparam int SLOTS   = KERNEL_TAPS + 1;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int IC_W    = (EFF_IC > 1) ? $clog2(EFF_IC) : 1;
   localparam int TAP_W   = (KERNEL_TAPS > 1) ? $clog2(KERNEL_TAPS) : 1;
   localparam int OC_W    = $clog2(EFF_OC);
   localparam int W_DEPTH = EFF_OC * EFF_IC * KERNEL_TAPS;
   localparam int WADDR_W = $clog2(W_DEPTH);
   localparam int H_DEPTH = SLOTS * (1 << IC_W);
   localparam int V_W     = tconv_pkg::VALUE_W;
   localparam int CH_W    = tconv_pkg::CH_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [CH_W-1:0]    oc_ff, oc_in;
   logic [WADDR_W-1:0] waddr_ff, waddr_in;
   logic [IC_W-1:0]    ic_ff, ic_in;
   logic [TAP_W-1:0]   tap_ff, tap_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SLOT_W-1:0]  first_slot_ff, first_slot_in;
   logic [SLOT_W-1:0]  newest_ff, newest_in;
   logic [SLOT_W-1:0]  after_newest;
   logic [SLOTS-1:0][EFF_IC-1:0] hvalid_ff, hvalid_in;

   logic            bias_vld_ff, bias_vld_in;
   logic            s1_vld_ff, s1_vld_in;
   logic            s1_last_ff, s1_last_in;
   logic            s1_hv_ff, s1_hv_in;
   logic            s2_vld_ff;
   logic            s2_last_ff;
   logic [V_W-1:0]  prod_ff, prod_in;
   logic [V_W-1:0]  acc_ff, acc_in;
   logic [2*V_W-1:0] mul_full;
   logic [V_W-1:0]  sample;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0] rsp_channel_ff, rsp_channel_in;
   logic [V_W-1:0]  rsp_value_ff, rsp_value_in;
   logic            rsp_load, out_free, step_last, issue;

   logic                    w_wr_en, b_wr_en, h_wr_en, b_rd_en;
   logic [V_W-1:0]          w_rd_data, b_rd_data, h_rd_data;
   logic [SLOT_W+IC_W-1:0]  h_wr_addr, h_rd_addr;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign after_newest = (newest_ff == SLOT_W'(SLOTS - 1)) ? '0 : newest_ff + SLOT_W'(1);
   assign issue        = (state_ff == ST_RUN);
   assign step_last    = (ic_ff == IC_W'(EFF_IC - 1)) && (tap_ff == TAP_W'(KERNEL_TAPS - 1));
   assign h_wr_addr    = {newest_ff, q_entry.channel[IC_W-1:0]};
   assign h_rd_addr    = {slot_ff, ic_ff};

   tconv_ram #(.WIDTH(V_W), .DEPTH(W_DEPTH)) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (q_entry.waddr[WADDR_W-1:0]),
      .wr_data (q_entry.value),
      .rd_en   (issue),
      .rd_addr (waddr_ff),
      .rd_data (w_rd_data)
   );

   tconv_ram #(.WIDTH(V_W), .DEPTH(EFF_OC)) u_bias_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (q_entry.channel[OC_W-1:0]),
      .wr_data (q_entry.value),
      .rd_en   (b_rd_en),
      .rd_addr (q_entry.channel[OC_W-1:0]),
      .rd_data (b_rd_data)
   );

   tconv_ram #(.WIDTH(V_W), .DEPTH(H_DEPTH)) u_hist_ram (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (h_wr_addr),
      .wr_data (q_entry.value),
      .rd_en   (issue),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd_data)
   );

   // front of the sequencer: queue pops, writes, step issue and result register loads
   always_comb begin
      state_in       = state_ff;
      q_pop          = 1'b0;
      w_wr_en        = 1'b0;
      b_wr_en        = 1'b0;
      h_wr_en        = 1'b0;
      b_rd_en        = 1'b0;
      bias_vld_in    = 1'b0;
      rsp_load       = 1'b0;
      rsp_channel_in = rsp_channel_ff;
      rsp_value_in   = rsp_value_ff;
      oc_in          = oc_ff;
      waddr_in       = waddr_ff;
      ic_in          = ic_ff;
      tap_in         = tap_ff;
      slot_in        = slot_ff;
      first_slot_in  = first_slot_ff;
      newest_in      = newest_ff;
      hvalid_in      = hvalid_ff;
      s1_vld_in      = 1'b0;
      s1_last_in     = 1'b0;
      s1_hv_in       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_entry.cmd)
                  tconv_pkg::CMD_WEIGHT: begin
                     q_pop   = 1'b1;
                     w_wr_en = 1'b1;
                  end
                  tconv_pkg::CMD_BIAS: begin
                     q_pop   = 1'b1;
                     b_wr_en = 1'b1;
                  end
                  tconv_pkg::CMD_SAMPLE: begin
                     q_pop   = 1'b1;
                     h_wr_en = 1'b1;
                     hvalid_in[newest_ff][q_entry.channel[IC_W-1:0]] = 1'b1;
                     if (q_entry.frame_end) begin
                        newest_in               = after_newest;
                        hvalid_in[after_newest] = '0;
                     end
                  end
                  tconv_pkg::CMD_COMPUTE: begin
                     if (out_free) begin
                        q_pop         = 1'b1;
                        b_rd_en       = 1'b1;
                        bias_vld_in   = 1'b1;
                        oc_in         = q_entry.channel;
                        waddr_in      = q_entry.waddr[WADDR_W-1:0];
                        ic_in         = '0;
                        tap_in        = '0;
                        slot_in       = after_newest;
                        first_slot_in = after_newest;
                        state_in      = ST_RUN;
                     end
                  end
                  tconv_pkg::CMD_ABSENT: begin
                     if (out_free) begin
                        q_pop          = 1'b1;
                        rsp_load       = 1'b1;
                        rsp_channel_in = q_entry.channel;
                        rsp_value_in   = '0;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_RUN: begin
            s1_vld_in  = 1'b1;
            s1_last_in = step_last;
            s1_hv_in   = hvalid_ff[slot_ff][ic_ff];
            waddr_in   = waddr_ff + WADDR_W'(1);
            if (tap_ff == TAP_W'(KERNEL_TAPS - 1)) begin
               tap_in  = '0;
               ic_in   = ic_ff + IC_W'(1);
               slot_in = first_slot_ff;
            end else begin
               tap_in  = tap_ff + TAP_W'(1);
               slot_in = (slot_ff == SLOT_W'(SLOTS - 1)) ? '0 : slot_ff + SLOT_W'(1);
            end
            if (step_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (s2_vld_ff && s2_last_ff) begin
               rsp_load       = 1'b1;
               rsp_channel_in = oc_ff;
               rsp_value_in   = acc_ff + prod_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // multiply-accumulate datapath
   assign sample   = s1_hv_ff ? h_rd_data : '0;
   assign mul_full = w_rd_data * sample;
   assign prod_in  = mul_full[V_W-1:0];

   always_comb begin
      acc_in = acc_ff;
      if (bias_vld_ff) begin
         acc_in = b_rd_data;
      end else if (s2_vld_ff) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         newest_ff    <= '0;
         hvalid_ff    <= '0;
         bias_vld_ff  <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         newest_ff    <= newest_in;
         hvalid_ff    <= hvalid_in;
         bias_vld_ff  <= bias_vld_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s1_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      oc_ff          <= oc_in;
      waddr_ff       <= waddr_in;
      ic_ff          <= ic_in;
      tap_ff         <= tap_in;
      slot_ff        <= slot_in;
      first_slot_ff  <= first_slot_in;
      s1_last_ff     <= s1_last_in;
      s1_hv_ff       <= s1_hv_in;
      s2_last_ff     <= s1_last_ff;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_value_ff   <= rsp_value_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_channel = rsp_channel_ff;
   assign rsp_result_value   = rsp_value_ff;

   `TCONV_ASSERT(a_result_in_drain, clock, reset, (s2_vld_ff && s2_last_ff) |-> (state_ff == ST_DRAIN), "last product outside drain")
   `TCONV_ASSERT_NEVER(a_no_overwrite, clock, reset, rsp_load && rsp_valid_ff && rsp_stall, "held item overwritten")
   `TCONV_ASSERT(a_pop_when_idle, clock, reset, q_pop |-> (q_valid && (state_ff == ST_IDLE)), "pop outside idle")
   `TCONV_ASSERT_NEVER(a_bias_overlap, clock, reset, bias_vld_ff && s2_vld_ff, "bias load collides with accumulate")

endmodule

/* hw/rtl/temporal_conv_layer_relu.sv */
// channel   direction  handshake               payload
// req       in         req_valid / req_stall   kind, out_channel, in_channel, tap, value
// rsp       out        rsp_valid / rsp_stall   result_channel, result_value
//
// weight, bias and sample items leave the queue while the sequencer is idle
// a compute item's products run one mac a cycle on the shared mac, through the s1 and s2
//   registers; no item leaves the queue until the sum is loaded into the rsp register
// reset is synchronous and clears control state and the valid bits of the sample history;
//   weights and biases hold no reset value
// req_stall rises when the four-item queue is full; the rsp output register lets
//   writes and samples go on while a result waits
module temporal_conv_layer_relu #(
   parameter int OUT_CHANNELS = 64,
   parameter int IN_CHANNELS  = 64,
   parameter int KERNEL_TAPS  = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [tconv_pkg::KIND_W-1:0]       req_kind,
   input  logic [tconv_pkg::CH_W-1:0]         req_out_channel,
   input  logic [tconv_pkg::CH_W-1:0]         req_in_channel,
   input  logic [tconv_pkg::TAP_FIELD_W-1:0]  req_tap,
   input  logic [tconv_pkg::VALUE_W-1:0]      req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tconv_pkg::CH_W-1:0]         rsp_result_channel,
   output logic [tconv_pkg::VALUE_W-1:0]      rsp_result_value
);

   logic                  q_full, q_push, q_pop, q_valid;
   tconv_pkg::qentry_type q_in_entry, q_head;

   tconv_front #(
      .OUT_CHANNELS (OUT_CHANNELS),
      .IN_CHANNELS  (IN_CHANNELS),
      .KERNEL_TAPS  (KERNEL_TAPS)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_out_channel (req_out_channel),
      .req_in_channel  (req_in_channel),
      .req_tap         (req_tap),
      .req_value       (req_value),
      .full            (q_full),
      .push            (q_push),
      .push_entry      (q_in_entry)
   );

   tconv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (q_head)
   );

   tconv_back #(
      .OUT_CHANNELS (OUT_CHANNELS),
      .IN_CHANNELS  (IN_CHANNELS),
      .KERNEL_TAPS  (KERNEL_TAPS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_entry            (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_channel (rsp_result_channel),
      .rsp_result_value   (rsp_result_value)
   );

endmodule
